/* rtl/clock_time_set_and_matrix_framer_assert.svh */
// Assertion macros for the clock time-set and matrix framer checks.
`ifndef CLOCK_TIME_SET_AND_MATRIX_FRAMER_ASSERT_SVH
`define CLOCK_TIME_SET_AND_MATRIX_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CTSMF_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CTSMF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ctsmf_pkg.sv */
// Shared types, codes, font table and helpers for the clock framer.
`timescale 1ns / 1ps
`default_nettype none

package ctsmf_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int NUM_COLS   = 32;

    typedef logic [3:0] digit_t;

    // request codes
    localparam logic [2:0] REQ_RENDER = 3'd0;
    localparam logic [2:0] REQ_TIME   = 3'd1;
    localparam logic [2:0] REQ_SET    = 3'd2;
    localparam logic [2:0] REQ_SHIFT  = 3'd3;
    localparam logic [2:0] REQ_APPLY  = 3'd4;

    // result kinds
    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    localparam logic [7:0] SEP_BYTE   = 8'hBD;
    localparam logic [7:0] BLANK_BYTE = 8'hFF;

    localparam logic [4:0] SEP_COL_A = 5'd10;
    localparam logic [4:0] SEP_COL_B = 5'd21;
    localparam logic [4:0] LAST_COL  = 5'd31;
    localparam logic [2:0] LAST_SUB  = 3'd4;
    localparam logic [2:0] LAST_DIG  = 3'd5;

    localparam logic [7:0] FONT_ROM [0:9][0:4] = '{
        '{8'h83, 8'h7D, 8'h7D, 8'h83, 8'hFF},
        '{8'hDF, 8'hBD, 8'h01, 8'hFD, 8'hFF},
        '{8'hB3, 8'h6D, 8'h6D, 8'h9D, 8'hFF},
        '{8'hBB, 8'h6D, 8'h6D, 8'h93, 8'hFF},
        '{8'h0F, 8'hEF, 8'hEF, 8'h01, 8'hFF},
        '{8'h0D, 8'h6D, 8'h6D, 8'h73, 8'hFF},
        '{8'h83, 8'h6D, 8'h6D, 8'hB3, 8'hFF},
        '{8'h7F, 8'h71, 8'h6F, 8'h1F, 8'hFF},
        '{8'h93, 8'h6D, 8'h6D, 8'h93, 8'hFF},
        '{8'h9B, 8'h6D, 8'h6D, 8'h83, 8'hFF}
    };

    // request to the shared divide/modulo unit
    typedef struct packed {
        logic       start;
        logic [5:0] dividend;
        logic [3:0] divisor;
    } divmod_req_t;

    // answer from the shared divide/modulo unit
    typedef struct packed {
        logic       done;
        logic [2:0] quot;
        logic [3:0] rem;
    } divmod_rsp_t;

    function automatic logic [7:0] glyph(input digit_t d, input logic [2:0] s);
        logic [7:0] b;
        b = BLANK_BYTE;
        if (d <= 4'd9 && s <= LAST_SUB) begin
            b = FONT_ROM[d][s];
        end
        return b;
    endfunction

    // wrap limit of the digit under the cursor
    function automatic logic [3:0] digit_limit(input logic [2:0] c, input digit_t hour_tens);
        logic [3:0] l;
        case (c)
            3'd0:    l = 4'd3;
            3'd1:    l = (hour_tens >= 4'd2) ? 4'd4 : 4'd10;
            3'd2:    l = 4'd6;
            3'd4:    l = 4'd6;
            default: l = 4'd10;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

/* rtl/ctsmf_req_if.sv */
// Request channel: one event per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface ctsmf_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [4:0] hours_in;
    logic [5:0] minutes_in;
    logic [5:0] seconds_in;

    modport source (output valid, output req_type, output hours_in, output minutes_in,
                    output seconds_in, input ready);
    modport sink   (input valid, input req_type, input hours_in, input minutes_in,
                    input seconds_in, output ready);
endinterface

`default_nettype wire

/* rtl/ctsmf_res_if.sv */
// Result channel: frame columns and clock write requests.
`timescale 1ns / 1ps
`default_nettype none

interface ctsmf_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [4:0] column_index;
    logic [7:0] column_byte;
    logic [4:0] set_hours;
    logic [5:0] set_minutes;
    logic [5:0] set_seconds;
    logic       last;

    modport source (output valid, output kind, output column_index, output column_byte,
                    output set_hours, output set_minutes, output set_seconds,
                    output last, input ready);
    modport sink   (input valid, input kind, input column_index, input column_byte,
                    input set_hours, input set_minutes, input set_seconds,
                    input last, output ready);
endinterface

`default_nettype wire

/* rtl/ctsmf_divmod.sv */
// Shared iterative divide/modulo unit: one compare-subtract per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ctsmf_divmod
    import ctsmf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire divmod_req_t req,
    output divmod_rsp_t      rsp
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [5:0] rem_reg, rem_next;
    logic [2:0] quot_reg, quot_next;
    logic [3:0] divisor_reg, divisor_next;

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            rem_next     = req.dividend;
            quot_next    = 3'd0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= {2'b00, divisor_reg})
            begin
                rem_next  = rem_reg - {2'b00, divisor_reg};
                quot_next = quot_reg + 3'd1;
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            rem_reg     <= '0;
            quot_reg    <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            rem_reg     <= rem_next;
            quot_reg    <= quot_next;
            divisor_reg <= divisor_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg[3:0];

endmodule

`default_nettype wire

/* rtl/clock_time_set_and_matrix_framer.sv */
// Top level: clock display events, manual time setting and 32-column framing.
// Usage:
//   req carries one event per transfer: render (0), time update (1),
//   set/change button (2), shift button (3) or apply button (4). Codes 5..7
//   are dropped. res carries the results; last marks the final one of an event.
//   Render yields 32 column bytes (index 0..31). Apply yields one clock write
//   (kind 1) with the edited time, then the 32 columns of the normal frame.
//   Time updates and buttons yield nothing.
// Sequencing:
//   The results of a render or apply are registered and follow one per
//   cycle while res.ready stays high. A time update runs the shared
//   divide/modulo unit three times (one compare-subtract per cycle); a
//   digit step runs it once. Shift and set-mode entry are done in idle.
//   req.ready is high only while the sequencer is idle; one event at a time.
// Stall:
//   The output register holds a result until res.ready; the sequencer waits
//   with it. The last result may sit in the register while the next event is
//   already taken.
// Reset: rst_n clears digits, cursor and set mode and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module clock_time_set_and_matrix_framer
    import ctsmf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ctsmf_req_if.sink   req,
    ctsmf_res_if.source res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_STEP,
        ST_WRITE,
        ST_FRAME
    } state_t;

    state_t      state_reg, state_next;

    digit_t      shown_reg [NUM_DIGITS];
    digit_t      shown_next [NUM_DIGITS];
    digit_t      edit_reg [NUM_DIGITS];
    digit_t      edit_next [NUM_DIGITS];
    logic [2:0]  cursor_reg, cursor_next;
    logic        set_mode_reg, set_mode_next;

    // time update operands and which one the divider works on
    logic [5:0]  time_reg [3];
    logic [5:0]  time_next [3];
    logic [1:0]  field_reg, field_next;

    // frame walk
    logic [4:0]  col_reg, col_next;
    logic [2:0]  dig_reg, dig_next;
    logic [2:0]  sub_reg, sub_next;

    divmod_req_t div_req_reg, div_req_next;
    divmod_rsp_t div_rsp;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [4:0]  out_col_reg, out_col_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic [4:0]  out_hours_reg, out_hours_next;
    logic [5:0]  out_minutes_reg, out_minutes_next;
    logic [5:0]  out_seconds_reg, out_seconds_next;
    logic        out_last_reg, out_last_next;

    logic        slot_free;
    logic [2:0]  dig_idx;
    digit_t      frame_digit;
    logic [7:0]  frame_byte;
    logic        frame_advance;
    logic [6:0]  hours_sum;
    logic [6:0]  minutes_sum;
    logic [6:0]  seconds_sum;

    function automatic logic [6:0] tens_units(input digit_t t, input digit_t u);
        logic [6:0] t7;
        t7 = {3'b000, t};
        return (t7 << 3) + (t7 << 1) + {3'b000, u};
    endfunction

    ctsmf_divmod u_divmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign slot_free = !out_valid_reg || res.ready;
    assign req.ready = (state_reg == ST_IDLE);

    assign hours_sum   = tens_units(edit_reg[0], edit_reg[1]);
    assign minutes_sum = tens_units(edit_reg[2], edit_reg[3]);
    assign seconds_sum = tens_units(edit_reg[4], edit_reg[5]);

    // column byte at the current frame position
    always_comb
    begin
        dig_idx       = (dig_reg <= LAST_DIG) ? dig_reg : 3'd0;
        frame_digit   = set_mode_reg ? edit_reg[dig_idx] : shown_reg[dig_idx];
        frame_byte    = BLANK_BYTE;
        frame_advance = 1'b0;
        if (set_mode_reg)
        begin
            // edited digits up to the cursor, packed, no separators
            if (dig_reg <= cursor_reg && dig_reg <= LAST_DIG)
            begin
                frame_byte    = glyph(frame_digit, sub_reg);
                frame_advance = 1'b1;
            end
        end
        else if (col_reg == SEP_COL_A || col_reg == SEP_COL_B)
        begin
            frame_byte = SEP_BYTE;
        end
        else
        begin
            if (dig_reg <= LAST_DIG)
            begin
                frame_byte = glyph(frame_digit, sub_reg);
            end
            frame_advance = 1'b1;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        shown_next       = shown_reg;
        edit_next        = edit_reg;
        cursor_next      = cursor_reg;
        set_mode_next    = set_mode_reg;
        time_next        = time_reg;
        field_next       = field_reg;
        col_next         = col_reg;
        dig_next         = dig_reg;
        sub_next         = sub_reg;
        div_req_next     = '0;
        out_valid_next   = out_valid_reg && !res.ready;
        out_kind_next    = out_kind_reg;
        out_col_next     = out_col_reg;
        out_byte_next    = out_byte_reg;
        out_hours_next   = out_hours_reg;
        out_minutes_next = out_minutes_reg;
        out_seconds_next = out_seconds_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.req_type)
                        REQ_RENDER:
                        begin
                            col_next   = '0;
                            dig_next   = '0;
                            sub_next   = '0;
                            state_next = ST_FRAME;
                        end
                        REQ_TIME:
                        begin
                            time_next[0]          = {1'b0, req.hours_in};
                            time_next[1]          = req.minutes_in;
                            time_next[2]          = req.seconds_in;
                            field_next            = 2'd0;
                            div_req_next.start    = 1'b1;
                            div_req_next.dividend = {1'b0, req.hours_in};
                            div_req_next.divisor  = 4'd10;
                            state_next            = ST_SPLIT;
                        end
                        REQ_SET:
                        begin
                            if (!set_mode_reg)
                            begin
                                set_mode_next = 1'b1;
                            end
                            else if (cursor_reg <= LAST_DIG)
                            begin
                                // step with wrap: (digit + 1) mod limit
                                div_req_next.start    = 1'b1;
                                div_req_next.dividend = {2'b00, edit_reg[cursor_reg]} + 6'd1;
                                div_req_next.divisor  = digit_limit(cursor_reg, edit_reg[0]);
                                state_next            = ST_STEP;
                            end
                        end
                        REQ_SHIFT:
                        begin
                            cursor_next = (cursor_reg >= LAST_DIG) ? 3'd0 : cursor_reg + 3'd1;
                        end
                        REQ_APPLY:
                        begin
                            state_next = ST_WRITE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SPLIT:
            begin
                if (div_rsp.done)
                begin
                    shown_next[{field_reg, 1'b0}] = {1'b0, div_rsp.quot};
                    shown_next[{field_reg, 1'b1}] = div_rsp.rem;
                    if (field_reg == 2'd2)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        field_next            = field_reg + 2'd1;
                        div_req_next.start    = 1'b1;
                        div_req_next.dividend = time_reg[field_reg + 2'd1];
                        div_req_next.divisor  = 4'd10;
                    end
                end
            end

            ST_STEP:
            begin
                if (div_rsp.done)
                begin
                    edit_next[cursor_reg] = div_rsp.rem;
                    state_next            = ST_IDLE;
                end
            end

            ST_WRITE:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = KIND_WRITE;
                    out_col_next     = '0;
                    out_byte_next    = '0;
                    out_hours_next   = hours_sum[4:0];
                    out_minutes_next = minutes_sum[5:0];
                    out_seconds_next = seconds_sum[5:0];
                    out_last_next    = 1'b0;
                    shown_next       = edit_reg;
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        edit_next[i] = '0;
                    end
                    cursor_next   = '0;
                    set_mode_next = 1'b0;
                    col_next      = '0;
                    dig_next      = '0;
                    sub_next      = '0;
                    state_next    = ST_FRAME;
                end
            end

            ST_FRAME:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = KIND_COLUMN;
                    out_col_next     = col_reg;
                    out_byte_next    = frame_byte;
                    out_hours_next   = '0;
                    out_minutes_next = '0;
                    out_seconds_next = '0;
                    out_last_next    = (col_reg == LAST_COL);
                    if (frame_advance)
                    begin
                        if (sub_reg == LAST_SUB)
                        begin
                            sub_next = '0;
                            dig_next = dig_reg + 3'd1;
                        end
                        else
                        begin
                            sub_next = sub_reg + 3'd1;
                        end
                    end
                    col_next = col_reg + 5'd1;
                    if (col_reg == LAST_COL)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                shown_reg[i] <= '0;
                edit_reg[i]  <= '0;
            end
            cursor_reg      <= '0;
            set_mode_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                time_reg[i] <= '0;
            end
            field_reg       <= '0;
            col_reg         <= '0;
            dig_reg         <= '0;
            sub_reg         <= '0;
            div_req_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= 1'b0;
            out_col_reg     <= '0;
            out_byte_reg    <= '0;
            out_hours_reg   <= '0;
            out_minutes_reg <= '0;
            out_seconds_reg <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            shown_reg       <= shown_next;
            edit_reg        <= edit_next;
            cursor_reg      <= cursor_next;
            set_mode_reg    <= set_mode_next;
            time_reg        <= time_next;
            field_reg       <= field_next;
            col_reg         <= col_next;
            dig_reg         <= dig_next;
            sub_reg         <= sub_next;
            div_req_reg     <= div_req_next;
            out_valid_reg   <= out_valid_next;
            out_kind_reg    <= out_kind_next;
            out_col_reg     <= out_col_next;
            out_byte_reg    <= out_byte_next;
            out_hours_reg   <= out_hours_next;
            out_minutes_reg <= out_minutes_next;
            out_seconds_reg <= out_seconds_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.kind         = out_kind_reg;
    assign res.column_index = out_col_reg;
    assign res.column_byte  = out_byte_reg;
    assign res.set_hours    = out_hours_reg;
    assign res.set_minutes  = out_minutes_reg;
    assign res.set_seconds  = out_seconds_reg;
    assign res.last         = out_last_reg;

endmodule

`default_nettype wire

/* rtl/ctsmf_checker.sv */
// Port-level checks for the clock framer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "clock_time_set_and_matrix_framer_assert.svh"

module ctsmf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_ready,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic       res_kind,
    input wire logic [4:0] res_column_index,
    input wire logic       res_last
);

    // no new event is taken while a frame is still streaming out
    `CTSMF_ASSERT_NOW(a_busy_while_streaming, clk, rst_n, res_valid && !res_last, !req_ready, "request taken mid-frame")

    // columns follow back to back in order
    `CTSMF_ASSERT_NEXT(a_column_order, clk, rst_n, res_valid && res_ready && !res_kind && !res_last, res_valid && !res_kind && (res_column_index == $past(res_column_index) + 5'd1), "frame column out of order")

    // last marks column 31 and only it
    `CTSMF_ASSERT_NOW(a_last_on_final_column, clk, rst_n, res_valid && !res_kind, res_last == (res_column_index == 5'd31), "last flag misplaced")

    // a clock write is never marked last and carries column index 0
    `CTSMF_ASSERT_NOW(a_write_not_last, clk, rst_n, res_valid && res_kind, !res_last && (res_column_index == 5'd0), "clock write marked last")

endmodule

bind clock_time_set_and_matrix_framer ctsmf_checker u_ctsmf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_ready        (req.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_kind         (res.kind),
    .res_column_index (res.column_index),
    .res_last         (res.last)
);

`default_nettype wire

/* verif/tb_clock_time_set_and_matrix_framer.sv */
// Testbench for the clock framer: directed and random events checked against a local predictor.
`timescale 1ns / 1ps

module tb_clock_time_set_and_matrix_framer;
    import ctsmf_pkg::*;

    // Request codes 5..7 are not decoded; the block must drop them silently.
    localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    // Hour-tens value from which the hour-units digit wraps at 4.
    localparam logic [3:0] HOUR_TENS_HIGH = 4'd2;

    // Print only the first few mismatches; all of them are counted.
    localparam int MAX_REPORTS = 40;

    // Quiet cycles after the last expected result. This covers a trailing
    // time update on the divide unit plus margin.
    localparam int DRAIN_CYCLES = 60;

    localparam int RANDOM_ITEMS = 350;

    // One result transfer as seen on the result channel.
    typedef struct packed {
        logic       kind;
        logic [4:0] column_index;
        logic [7:0] column_byte;
        logic [4:0] set_hours;
        logic [5:0] set_minutes;
        logic [5:0] set_seconds;
        logic       last;
    } framer_result_t;

    logic clk;
    logic rst_n;

    ctsmf_req_if req_bus ();
    ctsmf_res_if res_bus ();

    clock_time_set_and_matrix_framer u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .res   (res_bus)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of what the block holds.
    // ------------------------------------------------------------------
    digit_t     shown_q [NUM_DIGITS];
    digit_t     edit_q  [NUM_DIGITS];
    logic [2:0] cursor_q;
    logic       set_mode_q;

    // Results predicted but not yet seen, oldest first.
    framer_result_t pending_results [$];

    int mismatch_count;
    int results_seen;
    int items_sent;

    // Idle percentages for each side; changed per traffic phase.
    int send_idle_pct;
    int recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous fixed limit; a clean run finishes far earlier.
    initial
    begin
        #5_000_000;
        $display("tb_clock_time_set_and_matrix_framer: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Font lookup; digits above nine would be drawn blank.
    function automatic logic [7:0] font_column(input digit_t d, input int sub);
        logic [7:0] b;
        b = BLANK_BYTE;
        if (d <= 4'd9 && sub <= int'(LAST_SUB))
        begin
            b = FONT_ROM[d][sub];
        end
        return b;
    endfunction

    // Queue the 32 columns of a frame. Normal view puts the separator at
    // columns 10 and 21 and the six shown digits around it. Edit view draws
    // the edit digits 0..cursor back to back and blanks the rest.
    task automatic queue_frame(input bit edit_view);
        int             dig;
        int             sub;
        logic [7:0]     b;
        framer_result_t r;
        dig = 0;
        sub = 0;
        for (int col = 0; col < NUM_COLS; col++)
        begin
            if (edit_view)
            begin
                if (dig <= int'(cursor_q) && dig < NUM_DIGITS)
                begin
                    b = font_column(edit_q[dig], sub);
                    sub++;
                    if (sub == int'(LAST_SUB) + 1)
                    begin
                        sub = 0;
                        dig++;
                    end
                end
                else
                begin
                    b = BLANK_BYTE;
                end
            end
            else if (col == int'(SEP_COL_A) || col == int'(SEP_COL_B))
            begin
                b = SEP_BYTE;
            end
            else
            begin
                b = (dig < NUM_DIGITS) ? font_column(shown_q[dig], sub) : BLANK_BYTE;
                sub++;
                if (sub == int'(LAST_SUB) + 1)
                begin
                    sub = 0;
                    dig++;
                end
            end
            r              = '0;
            r.kind         = KIND_COLUMN;
            r.column_index = 5'(col);
            r.column_byte  = b;
            r.last         = (col == int'(LAST_COL));
            pending_results.push_back(r);
        end
    endtask

    // Update the predictor for one accepted event and queue its results.
    task automatic predict_event(input logic [2:0] code, input logic [4:0] hrs,
                                 input logic [5:0] mins, input logic [5:0] secs);
        int             lim;
        framer_result_t wr;
        case (code)
            REQ_RENDER:
            begin
                queue_frame(set_mode_q);
            end
            REQ_TIME:
            begin
                // Out-of-range values split the same way; digits stay 0..9.
                shown_q[0] = digit_t'(hrs / 10);
                shown_q[1] = digit_t'(hrs % 10);
                shown_q[2] = digit_t'(mins / 10);
                shown_q[3] = digit_t'(mins % 10);
                shown_q[4] = digit_t'(secs / 10);
                shown_q[5] = digit_t'(secs % 10);
            end
            REQ_SET:
            begin
                // First press only enters set mode; later presses step.
                if (!set_mode_q)
                begin
                    set_mode_q = 1'b1;
                end
                else if (cursor_q <= LAST_DIG)
                begin
                    case (cursor_q)
                        3'd0:    lim = 3;
                        3'd1:    lim = (edit_q[0] >= HOUR_TENS_HIGH) ? 4 : 10;
                        3'd2:    lim = 6;
                        3'd4:    lim = 6;
                        default: lim = 10;
                    endcase
                    edit_q[cursor_q] = digit_t'((int'(edit_q[cursor_q]) + 1) % lim);
                end
            end
            REQ_SHIFT:
            begin
                // Moves even outside set mode.
                cursor_q = (cursor_q >= LAST_DIG) ? 3'd0 : cursor_q + 3'd1;
            end
            REQ_APPLY:
            begin
                // Clock write first (hour unchecked), then a normal frame.
                wr             = '0;
                wr.kind        = KIND_WRITE;
                wr.set_hours   = 5'(int'(edit_q[0]) * 10 + int'(edit_q[1]));
                wr.set_minutes = 6'(int'(edit_q[2]) * 10 + int'(edit_q[3]));
                wr.set_seconds = 6'(int'(edit_q[4]) * 10 + int'(edit_q[5]));
                pending_results.push_back(wr);
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    shown_q[i] = edit_q[i];
                    edit_q[i]  = '0;
                end
                cursor_q   = '0;
                set_mode_q = 1'b0;
                queue_frame(1'b0);
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drive one event and hold it until the transfer. valid stays high
    // afterwards so back-to-back events need no low cycle; the next call
    // lowers it only if it decides to idle.
    task automatic send_event(input logic [2:0] code, input logic [4:0] hrs,
                              input logic [5:0] mins, input logic [5:0] secs);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= code;
        req_bus.hours_in   <= hrs;
        req_bus.minutes_in <= mins;
        req_bus.seconds_in <= secs;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        predict_event(code, hrs, mins, secs);
        if (code <= REQ_APPLY)
        begin
            items_sent++;
        end
    endtask

    // Event whose time fields are don't-care: fill them with noise.
    task automatic send_noisy(input logic [2:0] code);
        send_event(code, 5'($urandom), 6'($urandom), 6'($urandom));
    endtask

    // Time update mostly in the clock's range, sometimes over the full width.
    task automatic send_random_time();
        logic [4:0] hrs;
        logic [5:0] mins;
        logic [5:0] secs;
        if ($urandom_range(0, 3) == 0)
        begin
            hrs  = 5'($urandom_range(0, 31));
            mins = 6'($urandom_range(0, 63));
            secs = 6'($urandom_range(0, 63));
        end
        else
        begin
            hrs  = 5'($urandom_range(0, 23));
            mins = 6'($urandom_range(0, 59));
            secs = 6'($urandom_range(0, 59));
        end
        send_event(REQ_TIME, hrs, mins, secs);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order checking
    // ------------------------------------------------------------------

    // Low from time zero, then a fresh random pick at every edge.
    initial
    begin
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
        end
    endtask

    always @(posedge clk)
    begin
        framer_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind",         res_bus.kind,         want.kind);
                check_field("column_index", res_bus.column_index, want.column_index);
                check_field("column_byte",  res_bus.column_byte,  want.column_byte);
                check_field("set_hours",    res_bus.set_hours,    want.set_hours);
                check_field("set_minutes",  res_bus.set_minutes,  want.set_minutes);
                check_field("set_seconds",  res_bus.set_seconds,  want.set_seconds);
                check_field("last",         res_bus.last,         want.last);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Frame straight out of reset: all shown digits zero.
    task automatic test_render_after_reset();
        send_noisy(REQ_RENDER);
    endtask

    // All-ones time fields: hours 31, minutes and seconds 63 still split
    // into digits 3 1 6 3 6 3; the render shows them.
    task automatic test_time_update_extremes();
        send_event(REQ_TIME, 5'h1F, 6'h3F, 6'h3F);
        send_noisy(REQ_RENDER);
    endtask

    // Unused codes give no result and change nothing.
    task automatic test_unused_codes();
        for (int c = int'(REQ_UNUSED_LO); c <= int'(REQ_UNUSED_HI); c++)
        begin
            send_noisy(3'(c));
        end
    endtask

    // Shift moves the cursor while not in set mode; apply outside set mode
    // writes the (zero) edit digits and clears the cursor again.
    task automatic test_buttons_outside_set_mode();
        send_noisy(REQ_SHIFT);
        send_noisy(REQ_APPLY);
    endtask

    // Enter set mode, take hour tens to 2, wrap hour units at 4, walk the
    // cursor to the last digit, render the edit view, wrap the cursor to 0,
    // wrap hour tens from 2 to 0 and apply.
    task automatic test_set_mode_editing();
        send_noisy(REQ_SET);
        repeat (2) send_noisy(REQ_SET);
        send_noisy(REQ_SHIFT);
        repeat (4) send_noisy(REQ_SET);
        repeat (4) send_noisy(REQ_SHIFT);
        send_noisy(REQ_RENDER);
        send_noisy(REQ_SHIFT);
        send_noisy(REQ_SET);
        send_noisy(REQ_APPLY);
    endtask

    // Random traffic in three idle phases. About half is well-formed: time
    // updates followed by a render, and edit sessions that end in apply.
    // The rest is lone renders, lone buttons, lone applies, abandoned edits and unused codes.
    task automatic test_random_traffic(input int item_goal);
        int phase_goal;
        int pick;
        int op;
        int n_ops;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_goal = items_sent + item_goal / 3;
            while (items_sent < phase_goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                begin
                    send_random_time();
                    send_noisy(REQ_RENDER);
                end
                else if (pick < 55)
                begin
                    // edit session; some are left open on purpose
                    send_noisy(REQ_SET);
                    n_ops = $urandom_range(1, 12);
                    for (int i = 0; i < n_ops; i++)
                    begin
                        op = $urandom_range(0, 9);
                        if (op < 6)
                        begin
                            send_noisy(REQ_SET);
                        end
                        else if (op < 9)
                        begin
                            send_noisy(REQ_SHIFT);
                        end
                        else
                        begin
                            send_noisy(REQ_RENDER);
                        end
                    end
                    if ($urandom_range(0, 4) != 0)
                    begin
                        send_noisy(REQ_APPLY);
                    end
                end
                else if (pick < 75)
                begin
                    send_noisy(REQ_RENDER);
                end
                else if (pick < 85)
                begin
                    send_noisy($urandom_range(0, 1) ? REQ_SHIFT : REQ_SET);
                end
                else if (pick < 90)
                begin
                    send_noisy(REQ_APPLY);
                end
                else
                begin
                    send_noisy(3'($urandom_range(int'(REQ_UNUSED_LO), int'(REQ_UNUSED_HI))));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        // Every input known from time zero; reset held low at the start.
        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= REQ_RENDER;
        req_bus.hours_in   <= '0;
        req_bus.minutes_in <= '0;
        req_bus.seconds_in <= '0;

        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            shown_q[i] = '0;
            edit_q[i]  = '0;
        end
        cursor_q       = '0;
        set_mode_q     = 1'b0;
        mismatch_count = 0;
        results_seen   = 0;
        items_sent     = 0;

        // Directed part runs with the first idle mix.
        send_idle_pct = 23;
        recv_idle_pct = 78;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_render_after_reset();
        test_time_update_extremes();
        test_unused_codes();
        test_buttons_outside_set_mode();
        test_set_mode_editing();
        test_random_traffic(RANDOM_ITEMS);

        // The last transfer step made no assignment to valid, so lowering it
        // here is the only one in this step.
        req_bus.valid <= 1'b0;

        // Drain; the fixed limit above catches a block that stops answering.
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("tb_clock_time_set_and_matrix_framer: done, clean");
        end
        else
        begin
            $display("tb_clock_time_set_and_matrix_framer: done, errors");
        end
        $finish;
    end

endmodule
